@@ hw/rtl/mru_page_replacement_top_defines.svh @@
// Assertion helpers for the top-level RTL file.
`ifndef MRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH
`define MRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define MRU_PR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define MRU_PR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MRU_PR_ASSERT_SAME(lbl, ante, cons, msg)

`define MRU_PR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ hw/rtl/mru_pr_pkg.sv @@
package mru_pr_pkg;

  localparam int PAGE_W        = 16;
  localparam int SLOT_OUT_W    = 3;
  localparam int CNT_W         = 16;
  localparam int CFG_W         = 4;
  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RESOLVE
  } state_t;

  typedef struct packed {
    logic load;
    logic match;
    logic commit;
  } cmd_t;

endpackage

@@ hw/rtl/mru_pr_ifs.sv @@
interface mru_pr_in_if import mru_pr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page;
  logic              last_ref;

  modport source (output valid, output page, output last_ref, input ready);
  modport sink   (input valid, input page, input last_ref, output ready);
endinterface

interface mru_pr_out_if import mru_pr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [SLOT_OUT_W-1:0] slot;
  logic                  evicted;
  logic [PAGE_W-1:0]     evicted_page;
  logic [CNT_W-1:0]      fault_count;
  logic [CNT_W-1:0]      hit_count;

  modport source (output valid, output hit, output slot, output evicted,
                  output evicted_page, output fault_count, output hit_count,
                  input ready);
  modport sink   (input valid, input hit, input slot, input evicted,
                  input evicted_page, input fault_count, input hit_count,
                  output ready);
endinterface

interface mru_pr_cfg_if import mru_pr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] frames_in_use;

  modport source (output valid, output frames_in_use, input ready);
  modport sink   (input valid, input frames_in_use, output ready);
endinterface

@@ hw/rtl/mru_pr_ctrl.sv @@
module mru_pr_ctrl import mru_pr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        cmd.match = 1'b1;
        state_nxt = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ hw/rtl/mru_pr_dp.sv @@
module mru_pr_dp import mru_pr_pkg::*; #(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  logic [PAGE_W-1:0]     in_page,
  input  logic                  in_last,
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_data,
  output logic                  res_hit,
  output logic [SLOT_OUT_W-1:0] res_slot,
  output logic                  res_evicted,
  output logic [PAGE_W-1:0]     res_evicted_page,
  output logic [CNT_W-1:0]      res_fault_count,
  output logic [CNT_W-1:0]      res_hit_count
);

  localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FILL_W = $clog2(FRAMES + 1);
  localparam int CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;

  logic [PAGE_BITS-1:0] frame_page [FRAMES];
  logic [FRAMES-1:0]    valid_r;
  logic [FILL_W-1:0]    fill_r;
  logic [SLOT_W-1:0]    recent_r;
  logic [CNT_W-1:0]     faults_r;
  logic [CNT_W-1:0]     hits_r;
  logic [CFG_W-1:0]     frames_in_use_r;

  logic [PAGE_BITS-1:0] page_r;
  logic                 last_r;
  logic [FRAMES-1:0]    match_r;
  logic [PAGE_BITS-1:0] mru_page_r;

  logic                  hit_r;
  logic [SLOT_OUT_W-1:0] slot_r;
  logic                  evicted_r;
  logic [PAGE_W-1:0]     evicted_page_r;
  logic [CNT_W-1:0]      fault_cnt_r;
  logic [CNT_W-1:0]      hit_cnt_r;

  logic              hit_any;
  logic [SLOT_W-1:0] hit_slot;
  logic [CMP_W-1:0]  fiu_ext;
  logic [FILL_W-1:0] eff_frames;
  logic              has_free;
  logic [SLOT_W-1:0] new_slot;
  logic              do_evict;
  logic [CNT_W-1:0]  faults_nxt;
  logic [CNT_W-1:0]  hits_nxt;

  always_comb begin
    hit_slot = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_slot = SLOT_W'(i);
      end
    end
  end

  assign hit_any = |match_r;

  // A frame count of zero acts as one, and a count above the built size acts as that size.
  always_comb begin
    fiu_ext = CMP_W'(frames_in_use_r);
    if (fiu_ext == '0) begin
      eff_frames = FILL_W'(1);
    end else if (fiu_ext > CMP_W'(FRAMES)) begin
      eff_frames = FILL_W'(FRAMES);
    end else begin
      eff_frames = FILL_W'(fiu_ext);
    end
  end

  assign has_free = fill_r < eff_frames;

  always_comb begin
    do_evict = 1'b0;
    if (hit_any) begin
      new_slot = hit_slot;
    end else if (has_free) begin
      new_slot = SLOT_W'(fill_r);
    end else begin
      new_slot = recent_r;
      do_evict = valid_r[recent_r];
    end
  end

  assign faults_nxt = (!hit_any && faults_r != '1) ? faults_r + CNT_W'(1) : faults_r;
  assign hits_nxt   = (hit_any && hits_r != '1) ? hits_r + CNT_W'(1) : hits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= CFG_RESET;
    end else if (cfg_we) begin
      frames_in_use_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      fill_r   <= '0;
      recent_r <= '0;
      faults_r <= '0;
      hits_r   <= '0;
    end else if (cmd.commit) begin
      if (last_r) begin
        valid_r  <= '0;
        fill_r   <= '0;
        recent_r <= '0;
        faults_r <= '0;
        hits_r   <= '0;
      end else begin
        if (!hit_any) begin
          valid_r[new_slot] <= 1'b1;
          if (has_free) begin
            fill_r <= fill_r + FILL_W'(1);
          end
        end
        recent_r <= new_slot;
        faults_r <= faults_nxt;
        hits_r   <= hits_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !hit_any) begin
      frame_page[new_slot] <= page_r;
    end
    if (cmd.match) begin
      mru_page_r <= frame_page[recent_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r <= PAGE_BITS'(in_page);
      last_r <= in_last;
    end
    if (cmd.match) begin
      for (int i = 0; i < FRAMES; i++) begin
        match_r[i] <= valid_r[i] && (frame_page[i] == page_r);
      end
    end
    if (cmd.commit) begin
      hit_r          <= hit_any;
      slot_r         <= SLOT_OUT_W'(new_slot);
      evicted_r      <= do_evict;
      evicted_page_r <= do_evict ? PAGE_W'(mru_page_r) : '0;
      fault_cnt_r    <= faults_nxt;
      hit_cnt_r      <= hits_nxt;
    end
  end

  assign res_hit          = hit_r;
  assign res_slot         = slot_r;
  assign res_evicted      = evicted_r;
  assign res_evicted_page = evicted_page_r;
  assign res_fault_count  = fault_cnt_r;
  assign res_hit_count    = hit_cnt_r;

endmodule

@@ hw/rtl/mru_page_replacement_top.sv @@
// Channel  Dir  Beat contents
// in_ch    in   page, last_ref
// out_ch   out  hit, slot, evicted, evicted_page, fault_count, hit_count
// cfg_ch   in   frames_in_use
//
// Each reference passes through three steps: accept, a parallel compare against all frames,
// then resolve and commit; a new reference is accepted only after the last one has committed.
// The next reference is accepted while a finished result still waits in the output register.
// Commit stalls only while that register is full and not being taken.
// Synchronous reset clears frame valid bits, fill level, counts and the control state.
`include "mru_page_replacement_top_defines.svh"

module mru_page_replacement_top import mru_pr_pkg::*; #(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  mru_pr_in_if.sink   in_ch,
  mru_pr_out_if.source out_ch,
  mru_pr_cfg_if.sink  cfg_ch
);

  cmd_t cmd;

  assign cfg_ch.ready = 1'b1;

  mru_pr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  mru_pr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_page          (in_ch.page),
    .in_last          (in_ch.last_ref),
    .cfg_we           (cfg_ch.valid),
    .cfg_data         (cfg_ch.frames_in_use),
    .res_hit          (out_ch.hit),
    .res_slot         (out_ch.slot),
    .res_evicted      (out_ch.evicted),
    .res_evicted_page (out_ch.evicted_page),
    .res_fault_count  (out_ch.fault_count),
    .res_hit_count    (out_ch.hit_count)
  );

  `MRU_PR_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready,
    "input accepted while a reference is still in progress")
  `MRU_PR_ASSERT_SAME(a_commit_room, cmd.commit, !out_ch.valid || out_ch.ready,
    "result committed over a pending beat")
  `MRU_PR_ASSERT_SAME(a_hit_no_evict, out_ch.valid, !(out_ch.hit && out_ch.evicted),
    "hit reported together with an eviction")

endmodule
